>>> rtl/core/dno_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the direction normalizer.
// Depends on nothing; dno_out_if and the top level refer to it.
package dno_pkg;

  // Angle cosines in unsigned Q0.32, rounded to nearest.
  localparam logic [63:0] COS_PI8_Q32  = 64'd3968032378;
  localparam logic [63:0] COS_3PI8_Q32 = 64'd1643612827;

  // Extra fraction bits of the radicand (the square root then comes out in Q.8).
  localparam int unsigned DIST_FRAC = 16;

  typedef enum logic [2:0] {
    DIR_RIGHT     = 3'd0,
    DIR_UPRIGHT   = 3'd1,
    DIR_UP        = 3'd2,
    DIR_UPLEFT    = 3'd3,
    DIR_LEFT      = 3'd4,
    DIR_DOWNLEFT  = 3'd5,
    DIR_DOWN      = 3'd6,
    DIR_DOWNRIGHT = 3'd7
  } dir_t;

endpackage

>>> rtl/core/dno_in_if.sv
`timescale 1ns / 1ps
// Input channel of the direction normalizer: object and target positions.
// Depends on nothing.
interface dno_in_if #(
  parameter int POS_WIDTH = 24
);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] object_x;
  logic signed [POS_WIDTH-1:0] object_y;
  logic signed [POS_WIDTH-1:0] target_x;
  logic signed [POS_WIDTH-1:0] target_y;

  modport source (output valid, object_x, object_y, target_x, target_y, input ready);
  modport sink   (input valid, object_x, object_y, target_x, target_y, output ready);
endinterface

>>> rtl/core/dno_out_if.sv
`timescale 1ns / 1ps
// Output channel of the direction normalizer: unit steps and move direction.
// Depends on dno_pkg for the direction type.
interface dno_out_if #(
  parameter int STEP_FRAC_BITS = 15
);
  logic                           valid;
  logic                           ready;
  logic signed [STEP_FRAC_BITS:0] unit_step_x;
  logic signed [STEP_FRAC_BITS:0] unit_step_y;
  dno_pkg::dir_t                  move_dir;
  logic                           keep_previous;

  modport source (output valid, unit_step_x, unit_step_y, move_dir, keep_previous,
                  input ready);
  modport sink   (input valid, unit_step_x, unit_step_y, move_dir, keep_previous,
                  output ready);
endinterface

>>> rtl/core/direction_normalize_octant.sv
`timescale 1ns / 1ps
// Direction normalizer top level: pipelined square root, divider and octant logic.
// Depends on dno_pkg, dno_in_if and dno_out_if.

// Takes one word per cycle while the pipe is not halted and returns one result
// word per input. Its register stages are, in order: difference, magnitude,
// squares and sum; the bit-serial square root (POS_WIDTH + 9 stages, one per
// root bit); the two dividers (STEP_FRAC_BITS + 1 stages, one per quotient
// bit); and the output register.
// The whole pipe moves together; it halts only while a result sits unread.
module direction_normalize_octant #(
  parameter int POS_WIDTH      = 24,
  parameter int STEP_FRAC_BITS = 15
) (
  input logic      clk,
  input logic      rst,
  dno_in_if.sink   req,
  dno_out_if.source rsp
);

  localparam int M     = POS_WIDTH;
  localparam int F     = STEP_FRAC_BITS;
  localparam int R     = M + 9;      // root bits
  localparam int RAD_W = 2 * R;      // radicand bits
  localparam int REM_W = R + 3;      // square-root remainder bits
  localparam int DR    = R + 1;      // divider remainder bits

  localparam logic [63:0] T1_U =
    (dno_pkg::COS_PI8_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [63:0] T2_U =
    (dno_pkg::COS_3PI8_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic signed [F+1:0] T1 = (F+2)'(T1_U);
  localparam logic signed [F+1:0] T2 = (F+2)'(T2_U);

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Difference stage.
  logic              a_valid;
  logic signed [M:0] a_dx, a_dy;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= req.valid;
    end
    if (en) begin
      a_dx <= {req.target_x[M-1], req.target_x} - {req.object_x[M-1], req.object_x};
      a_dy <= {req.target_y[M-1], req.target_y} - {req.object_y[M-1], req.object_y};
    end
  end

  // Magnitude stage.
  logic         b_valid, b_negx, b_negy, b_zero;
  logic [M-1:0] b_ax, b_ay;
  logic [M:0]   ax_full, ay_full;
  assign ax_full = a_dx[M] ? (-a_dx) : a_dx;
  assign ay_full = a_dy[M] ? (-a_dy) : a_dy;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_ax   <= ax_full[M-1:0];
      b_ay   <= ay_full[M-1:0];
      b_negx <= a_dx[M];
      b_negy <= a_dy[M];
      b_zero <= (a_dx == '0) && (a_dy == '0);
    end
  end

  // Square stage.
  logic           c_valid, c_negx, c_negy, c_zero;
  logic [M-1:0]   c_ax, c_ay;
  logic [2*M-1:0] c_sqx, c_sqy;
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_sqx  <= b_ax * b_ax;
      c_sqy  <= b_ay * b_ay;
      c_ax   <= b_ax;
      c_ay   <= b_ay;
      c_negx <= b_negx;
      c_negy <= b_negy;
      c_zero <= b_zero;
    end
  end

  // Sum stage.
  logic         d_valid, d_negx, d_negy, d_zero;
  logic [M-1:0] d_ax, d_ay;
  logic [2*M:0] d_sum;
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_sum  <= {1'b0, c_sqx} + {1'b0, c_sqy};
      d_ax   <= c_ax;
      d_ay   <= c_ay;
      d_negx <= c_negx;
      d_negy <= c_negy;
      d_zero <= c_zero;
    end
  end

  // Square root, one root bit per stage; radicand is the sum in Q.16.
  logic             sq_valid [0:R];
  logic             sq_negx  [0:R];
  logic             sq_negy  [0:R];
  logic             sq_zero  [0:R];
  logic [M-1:0]     sq_ax    [0:R];
  logic [M-1:0]     sq_ay    [0:R];
  logic [RAD_W-1:0] sq_rad   [0:R];
  logic [REM_W-1:0] sq_rem   [0:R];
  logic [R-1:0]     sq_root  [0:R];

  assign sq_valid[0] = d_valid;
  assign sq_negx[0]  = d_negx;
  assign sq_negy[0]  = d_negy;
  assign sq_zero[0]  = d_zero;
  assign sq_ax[0]    = d_ax;
  assign sq_ay[0]    = d_ay;
  assign sq_rad[0]   = RAD_W'({d_sum, {dno_pkg::DIST_FRAC{1'b0}}});
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;

  for (genvar k = 0; k < R; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh, trial, rem_sub;
    logic             ge;
    always_comb begin
      rem_sh  = {sq_rem[k][REM_W-3:0], sq_rad[k][RAD_W-1-2*k -: 2]};
      trial   = {1'b0, sq_root[k], 2'b01};
      ge      = rem_sh >= trial;
      rem_sub = rem_sh - trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (en) begin
        sq_valid[k+1] <= sq_valid[k];
      end
      if (en) begin
        sq_rem[k+1]  <= ge ? rem_sub : rem_sh;
        sq_root[k+1] <= {sq_root[k][R-2:0], ge};
        sq_rad[k+1]  <= sq_rad[k];
        sq_ax[k+1]   <= sq_ax[k];
        sq_ay[k+1]   <= sq_ay[k];
        sq_negx[k+1] <= sq_negx[k];
        sq_negy[k+1] <= sq_negy[k];
        sq_zero[k+1] <= sq_zero[k];
      end
    end
  end

  // Two restoring dividers, one quotient bit per stage. Since the distance is
  // at least 256 times either magnitude, F+1 quotient bits cover the result.
  logic          dv_valid [0:F+1];
  logic          dv_negx  [0:F+1];
  logic          dv_negy  [0:F+1];
  logic          dv_zero  [0:F+1];
  logic [R-1:0]  dv_h     [0:F+1];
  logic [DR-1:0] dv_remx  [0:F+1];
  logic [DR-1:0] dv_remy  [0:F+1];
  logic [F:0]    dv_qx    [0:F+1];
  logic [F:0]    dv_qy    [0:F+1];

  assign dv_valid[0] = sq_valid[R];
  assign dv_negx[0]  = sq_negx[R];
  assign dv_negy[0]  = sq_negy[R];
  assign dv_zero[0]  = sq_zero[R];
  assign dv_h[0]     = sq_root[R];
  assign dv_remx[0]  = DR'(sq_ax[R]) << 7;
  assign dv_remy[0]  = DR'(sq_ay[R]) << 7;
  assign dv_qx[0]    = '0;
  assign dv_qy[0]    = '0;

  for (genvar j = 0; j <= F; j++) begin : g_div
    logic [DR-1:0] tx, ty, hh;
    logic          gex, gey;
    always_comb begin
      hh  = {1'b0, dv_h[j]};
      tx  = {dv_remx[j][DR-2:0], 1'b0};
      ty  = {dv_remy[j][DR-2:0], 1'b0};
      gex = tx >= hh;
      gey = ty >= hh;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (en) begin
        dv_valid[j+1] <= dv_valid[j];
      end
      if (en) begin
        dv_remx[j+1] <= gex ? (tx - hh) : tx;
        dv_remy[j+1] <= gey ? (ty - hh) : ty;
        dv_qx[j+1]   <= {dv_qx[j][F-1:0], gex};
        dv_qy[j+1]   <= {dv_qy[j][F-1:0], gey};
        dv_h[j+1]    <= dv_h[j];
        dv_negx[j+1] <= dv_negx[j];
        dv_negy[j+1] <= dv_negy[j];
        dv_zero[j+1] <= dv_zero[j];
      end
    end
  end

  // Saturation, sign and octant classification into the output register.
  logic [F-1:0]      magx, magy;
  logic signed [F+1:0] sx, sy;
  logic              up;
  dno_pkg::dir_t     dir;
  always_comb begin
    magx = dv_qx[F+1][F] ? {F{1'b1}} : dv_qx[F+1][F-1:0];
    magy = dv_qy[F+1][F] ? {F{1'b1}} : dv_qy[F+1][F-1:0];
    sx   = dv_negx[F+1] ? -$signed({2'b00, magx}) : $signed({2'b00, magx});
    sy   = dv_negy[F+1] ? -$signed({2'b00, magy}) : $signed({2'b00, magy});
    up   = sy > 0;
    if (sx > T1) begin
      dir = dno_pkg::DIR_RIGHT;
    end else if (sx > T2) begin
      dir = up ? dno_pkg::DIR_UPRIGHT : dno_pkg::DIR_DOWNRIGHT;
    end else if (sx > -T2) begin
      dir = up ? dno_pkg::DIR_UP : dno_pkg::DIR_DOWN;
    end else if (sx > -T1) begin
      dir = up ? dno_pkg::DIR_UPLEFT : dno_pkg::DIR_DOWNLEFT;
    end else begin
      dir = dno_pkg::DIR_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv_valid[F+1];
    end
    if (en) begin
      if (dv_zero[F+1]) begin
        rsp.unit_step_x   <= '0;
        rsp.unit_step_y   <= '0;
        rsp.move_dir      <= dno_pkg::DIR_RIGHT;
        rsp.keep_previous <= 1'b1;
      end else begin
        rsp.unit_step_x   <= sx[F:0];
        rsp.unit_step_y   <= sy[F:0];
        rsp.move_dir      <= dir;
        rsp.keep_previous <= 1'b0;
      end
    end
  end

endmodule
